// ===== rtl/core/wlm_pkg.sv =====
package wlm_pkg;

   // fixed field widths
   localparam int COORD_BITS     = 10;
   localparam int CFG_BITS       = 11;
   localparam int CSR_INDEX_BITS = 1;

   // frame size limits and reset values
   localparam int MIN_DIM        = 3;
   localparam int MAX_ROWS       = 1024;
   localparam logic [CFG_BITS-1:0] FRAME_COLS_RESET = 11'd5;
   localparam logic [CFG_BITS-1:0] FRAME_ROWS_RESET = 11'd6;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_COLS = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_ROWS = 1'b1;

   // per-pixel tag worked out by the front end
   typedef struct packed {
      logic                  center_ok;
      logic [COORD_BITS-1:0] peak_row;
      logic [COORD_BITS-1:0] peak_col;
   } wlm_tag_type;

endpackage

// ===== rtl/core/wlm_ram.sv =====
module wlm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     ren,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read-first: a read at the address being written returns the old word
   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[waddr] <= wdata;
      end
      if (ren) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/wlm_fifo.sv =====
module wlm_fifo #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == NW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/wlm_front.sv =====
module wlm_front #(
   parameter int MAX_COLS   = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [wlm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [wlm_pkg::CFG_BITS-1:0]         csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [PIXEL_BITS-1:0]                req_pixel,
   input  logic                                 req_sof,
   input  logic                                 queue_full,
   output logic                                 push,
   output logic [PIXEL_BITS-1:0]                push_pixel,
   output logic [$clog2(MAX_COLS)-1:0]          push_col,
   output wlm_pkg::wlm_tag_type                 push_tag
);

   localparam int CW  = $clog2(MAX_COLS);
   localparam int CLW = $clog2(MAX_COLS + 1);
   localparam int DW  = (CLW > wlm_pkg::CFG_BITS) ? CLW : wlm_pkg::CFG_BITS;
   localparam int RW  = wlm_pkg::CFG_BITS;

   logic [wlm_pkg::CFG_BITS-1:0] cfg_cols_ff, cfg_cols_in;
   logic [wlm_pkg::CFG_BITS-1:0] cfg_rows_ff, cfg_rows_in;
   logic [CW-1:0]                col_ff, col_in;
   logic [wlm_pkg::COORD_BITS-1:0] row_ff, row_in;

   logic [DW-1:0] cols, cfg_cols_ext, c_start, c_cur, c_next, c_m1;
   logic [RW-1:0] rows, r_start, r_cur, r_next, r_m1;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      cfg_cols_in = cfg_cols_ff;
      cfg_rows_in = cfg_rows_ff;
      if (csr_wen && csr_index == wlm_pkg::CSR_FRAME_COLS) begin
         cfg_cols_in = csr_wdata;
      end
      if (csr_wen && csr_index == wlm_pkg::CSR_FRAME_ROWS) begin
         cfg_rows_in = csr_wdata;
      end
   end

   // saturate frame size to the supported range
   always_comb begin
      cfg_cols_ext = DW'(cfg_cols_ff);
      if (cfg_cols_ext < DW'(wlm_pkg::MIN_DIM)) begin
         cols = DW'(wlm_pkg::MIN_DIM);
      end else if (cfg_cols_ext > DW'(MAX_COLS)) begin
         cols = DW'(MAX_COLS);
      end else begin
         cols = cfg_cols_ext;
      end
      if (cfg_rows_ff < RW'(wlm_pkg::MIN_DIM)) begin
         rows = RW'(wlm_pkg::MIN_DIM);
      end else if (cfg_rows_ff > RW'(wlm_pkg::MAX_ROWS)) begin
         rows = RW'(wlm_pkg::MAX_ROWS);
      end else begin
         rows = cfg_rows_ff;
      end
   end

   // position of this pixel, then position of the next one
   always_comb begin
      c_start = req_sof ? '0 : DW'(col_ff);
      r_start = req_sof ? '0 : RW'(row_ff);
      c_cur   = c_start;
      r_cur   = r_start;
      if (c_start >= cols) begin
         c_cur = '0;
         r_cur = r_start + RW'(1);
      end
      if (r_cur >= rows) begin
         r_cur = '0;
      end
      c_next = c_cur + DW'(1);
      r_next = r_cur;
      if (c_next >= cols) begin
         c_next = '0;
         r_next = r_cur + RW'(1);
         if (r_next >= rows) begin
            r_next = '0;
         end
      end
      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         col_in = c_next[CW-1:0];
         row_in = r_next[wlm_pkg::COORD_BITS-1:0];
      end
      c_m1 = c_cur - DW'(1);
      r_m1 = r_cur - RW'(1);
   end

   assign push_pixel         = req_pixel;
   assign push_col           = c_cur[CW-1:0];
   assign push_tag.center_ok = (r_cur >= RW'(2)) && (c_cur >= DW'(2));
   assign push_tag.peak_row  = r_m1[wlm_pkg::COORD_BITS-1:0];
   assign push_tag.peak_col  = c_m1[wlm_pkg::COORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cols_ff <= wlm_pkg::FRAME_COLS_RESET;
         cfg_rows_ff <= wlm_pkg::FRAME_ROWS_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         cfg_cols_ff <= cfg_cols_in;
         cfg_rows_ff <= cfg_rows_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

endmodule

// ===== rtl/core/wlm_back.sv =====
module wlm_back #(
   parameter int MAX_COLS   = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 queue_valid,
   output logic                                 queue_pop,
   input  logic [PIXEL_BITS-1:0]                queue_pixel,
   input  logic [$clog2(MAX_COLS)-1:0]          queue_col,
   input  wlm_pkg::wlm_tag_type                 queue_tag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [wlm_pkg::COORD_BITS-1:0]       rsp_row,
   output logic [wlm_pkg::COORD_BITS-1:0]       rsp_col,
   output logic [PIXEL_BITS-1:0]                rsp_value
);

   localparam int CW = $clog2(MAX_COLS);

   // execute stage
   logic                  b_valid_ff, b_valid_in;
   logic [PIXEL_BITS-1:0] b_pixel_ff;
   logic [CW-1:0]         b_col_ff;
   wlm_pkg::wlm_tag_type  b_tag_ff;
   logic                  hz_ff, hz_in;
   logic [PIXEL_BITS-1:0] fwd_up_ff, fwd_mid_ff;
   logic                  b_exec;

   logic [PIXEL_BITS-1:0] up_rdata, mid_rdata, up_eff, mid_eff;

   logic signed [PIXEL_BITS-1:0] win_ff [9];
   logic signed [PIXEL_BITS-1:0] win_in [9];
   logic                         peak_hit;

   // output register
   logic                            out_valid_ff, out_valid_in;
   logic [wlm_pkg::COORD_BITS-1:0]  out_row_ff, out_col_ff;
   logic [PIXEL_BITS-1:0]           out_value_ff;

   assign b_exec    = b_valid_ff && (!out_valid_ff || rsp_ready);
   assign queue_pop = queue_valid && (!b_valid_ff || b_exec);

   // a pixel read at the column being written this cycle takes the new words
   assign hz_in   = b_exec && (queue_col == b_col_ff);
   assign up_eff  = hz_ff ? fwd_up_ff  : up_rdata;
   assign mid_eff = hz_ff ? fwd_mid_ff : mid_rdata;

   wlm_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_upper (
      .clock (clock),
      .wen   (b_exec),
      .waddr (b_col_ff),
      .wdata (mid_eff),
      .ren   (queue_pop),
      .raddr (queue_col),
      .rdata (up_rdata)
   );

   wlm_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_COLS)) u_middle (
      .clock (clock),
      .wen   (b_exec),
      .waddr (b_col_ff),
      .wdata (b_pixel_ff),
      .ren   (queue_pop),
      .raddr (queue_col),
      .rdata (mid_rdata)
   );

   // shift window left one column, newest column enters on the right
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3+0] = win_ff[k*3+1];
         win_in[k*3+1] = win_ff[k*3+2];
      end
      win_in[2] = $signed(up_eff);
      win_in[5] = $signed(mid_eff);
      win_in[8] = $signed(b_pixel_ff);
   end

   always_comb begin
      peak_hit = b_tag_ff.center_ok;
      for (int k = 0; k < 9; k++) begin
         if (k != 4 && !(win_in[4] > win_in[k])) begin
            peak_hit = 1'b0;
         end
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (queue_pop) begin
         b_valid_in = 1'b1;
      end else if (b_exec) begin
         b_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (b_exec) begin
         out_valid_in = peak_hit;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         hz_ff        <= 1'b0;
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
         if (queue_pop) begin
            hz_ff <= hz_in;
         end
         if (b_exec) begin
            for (int k = 0; k < 9; k++) begin
               win_ff[k] <= win_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         b_pixel_ff <= queue_pixel;
         b_col_ff   <= queue_col;
         b_tag_ff   <= queue_tag;
         fwd_up_ff  <= mid_eff;
         fwd_mid_ff <= b_pixel_ff;
      end
      if (b_exec && peak_hit) begin
         out_row_ff   <= b_tag_ff.peak_row;
         out_col_ff   <= b_tag_ff.peak_col;
         out_value_ff <= win_in[4];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_row   = out_row_ff;
   assign rsp_col   = out_col_ff;
   assign rsp_value = out_value_ff;

   a_hit_shows: assert property (@(posedge clock) disable iff (reset)
      (b_exec && peak_hit) |=> rsp_valid)
      else $error("detected peak not presented on the result port");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !b_exec)
      else $error("stalled result overwritten");

   a_fwd_set: assert property (@(posedge clock) disable iff (reset)
      (queue_pop && b_exec && queue_col == b_col_ff) |=> (hz_ff && b_valid_ff))
      else $error("column hazard not forwarded");

endmodule

// ===== rtl/core/window_local_maximum_detect.sv =====
// A peak's report leaves rsp_ once its below-right pixel passes queue, execute and output stage.
// Throughput: one pixel per clock; req_tready drops only when the 4-entry queue is full.
// The line-store RAMs (one read and one write port each) set that figure.
// Reset (synchronous, active high): clears counters, queue, window and output valid,
// loads frame_cols = 5 and frame_rows = 6; line stores keep their contents, no clearing pass.
module window_local_maximum_detect #(
   parameter int MAX_COLS   = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write port
   input  logic                                csr_wen,
   input  logic [wlm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wlm_pkg::CFG_BITS-1:0]        csr_wdata,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((PIXEL_BITS+7)/8)*8-1:0]     req_tdata,  // pixel_value, zero pad
   input  logic                                req_tuser,  // start_of_frame
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((2*wlm_pkg::COORD_BITS+PIXEL_BITS+7)/8)*8-1:0]
                                               rsp_tdata   // peak_row, peak_col, peak_value, pad
);

   localparam int CW    = $clog2(MAX_COLS);
   localparam int TAGW  = $bits(wlm_pkg::wlm_tag_type);
   localparam int QW    = TAGW + CW + PIXEL_BITS;
   localparam int RSP_W = ((2*wlm_pkg::COORD_BITS+PIXEL_BITS+7)/8)*8;
   localparam int QUEUE_DEPTH = 4;

   // front end -> queue
   logic                  push, queue_full;
   logic [PIXEL_BITS-1:0] push_pixel;
   logic [CW-1:0]         push_col;
   wlm_pkg::wlm_tag_type  push_tag;

   // queue -> back end
   logic                  queue_valid, queue_pop;
   logic [QW-1:0]         queue_data;
   logic [PIXEL_BITS-1:0] queue_pixel;
   logic [CW-1:0]         queue_col;
   wlm_pkg::wlm_tag_type  queue_tag;

   logic [wlm_pkg::COORD_BITS-1:0] rsp_row, rsp_col;
   logic [PIXEL_BITS-1:0]          rsp_value;

   // Front: hold the frame size registers and the raster counters, tag each
   // request with its column address and whether it completes a full window.
   wlm_front #(.MAX_COLS(MAX_COLS), .PIXEL_BITS(PIXEL_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_pixel  (req_tdata[PIXEL_BITS-1:0]),
      .req_sof    (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_pixel (push_pixel),
      .push_col   (push_col),
      .push_tag   (push_tag)
   );

   // Queue: decouple the counters from the line stores so a stalled result
   // does not back up into the pixel source right away.
   wlm_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_tag, push_col, push_pixel}),
      .full      (queue_full),
      .pop_valid (queue_valid),
      .pop       (queue_pop),
      .pop_data  (queue_data)
   );

   assign queue_pixel = queue_data[PIXEL_BITS-1:0];
   assign queue_col   = queue_data[PIXEL_BITS +: CW];
   assign queue_tag   = queue_data[PIXEL_BITS+CW +: TAGW];

   // Back: read both line stores at the column, rotate them, advance the 3x3
   // window and compare the center against its eight neighbors.
   wlm_back #(.MAX_COLS(MAX_COLS), .PIXEL_BITS(PIXEL_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (queue_valid),
      .queue_pop   (queue_pop),
      .queue_pixel (queue_pixel),
      .queue_col   (queue_col),
      .queue_tag   (queue_tag),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_row     (rsp_row),
      .rsp_col     (rsp_col),
      .rsp_value   (rsp_value)
   );

   // pack the report, lowest field first, pad bits zero
   assign rsp_tdata = RSP_W'({rsp_value, rsp_col, rsp_row});

endmodule
